[rtl/core/pattern_sequenced_led_pwm_unit_defines.svh]
// Assertion macros shared by the checker of the LED PWM sequencer.
`ifndef PATTERN_SEQUENCED_LED_PWM_UNIT_DEFINES_SVH
`define PATTERN_SEQUENCED_LED_PWM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, disabled while in reset.
`define PSLP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pslp check failed");

// Next-cycle implication, sampled on aclk, disabled while in reset.
`define PSLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pslp check failed");

`endif

[rtl/core/pslp_pkg.sv]
// Types and constants of the pattern-sequenced LED PWM unit.
package pslp_pkg;

    typedef logic [10:0] duty_t;
    typedef logic [15:0] ticks_t;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        CFG_PWM_PERIOD      = 2'd0,
        CFG_PRESCALE        = 2'd1,
        CFG_RESYNC_INTERVAL = 2'd2,
        CFG_RESYNC_ENABLE   = 2'd3
    } cfg_idx_t;

    localparam duty_t  PWM_PERIOD_RST      = 11'd2000;
    localparam ticks_t PRESCALE_RST        = 16'd100;
    localparam ticks_t RESYNC_INTERVAL_RST = 16'd5000;
    localparam logic   RESYNC_ENABLE_RST   = 1'b1;

    typedef enum logic [2:0] {
        MODE_LOAD      = 3'd0,
        MODE_UP        = 3'd1,
        MODE_DOWN      = 3'd2,
        MODE_WAIT_UP   = 3'd3,
        MODE_WAIT_DOWN = 3'd4,
        MODE_JUMP      = 3'd5,
        MODE_REST      = 3'd6
    } mode_t;

    typedef struct packed {
        duty_t  target;
        ticks_t ramp;
        ticks_t rest;
        logic   last;
    } step_entry_t;

    typedef struct packed {
        logic        action;
        logic [1:0]  channel;
        logic [2:0]  step_index;
        duty_t       target_duty;
        ticks_t      ramp_ticks;
        ticks_t      rest_ticks;
        logic        last_step;
    } pslp_in_t;

    typedef struct packed {
        logic  led0_on;
        logic  led1_on;
        logic  led2_on;
        duty_t duty0;
        duty_t duty1;
        duty_t duty2;
    } pslp_out_t;

    typedef struct packed {
        logic tick;
        logic restart;
        logic wr_en;
    } pslp_chan_ctrl_t;

endpackage

[rtl/core/pattern_sequenced_led_pwm_unit.sv]
// Top level of the pattern-sequenced LED PWM unit.
//
// Input channel (s_valid/s_ready/s_data): each request is either a time tick
// (action 0) or a write of one pattern step (action 1) into a channel's
// pattern memory. Every tick yields exactly one result on the m_ channel:
// the three PWM outputs for that tick and the duty levels after its
// sequencer step. Writes yield nothing.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// PWM period, prescaler, resync interval and resync enable; it is always
// ready and is meant to be used only while the unit is idle.
// A tick accepted into the input register moves on to the result register,
// from which the receiver can take it. Requests flow at one per clock while
// the receiver keeps up, set by the single-pass step logic between the two
// registers.
// When the receiver stalls, the result register holds its request and the
// input register may still take one more; s_ready falls only when both hold.
// Reset (synchronous, active low) restores the register defaults, sets all
// channels to load their first step at duty zero and empties both stages.
// Pattern memory is not cleared: write a step before a channel reads it.
module pattern_sequenced_led_pwm_unit #(
    parameter int NUM_CHANNELS = 3,
    parameter int MAX_STEPS    = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pslp_pkg::pslp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pslp_pkg::pslp_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  pslp_pkg::cfg_idx_t  cfg_index,
    input  logic [15:0]         cfg_data
);
    import pslp_pkg::*;

    localparam int PTR_W = $clog2(MAX_STEPS);
    localparam int LANES = (NUM_CHANNELS > 3) ? NUM_CHANNELS : 3;

    // Configuration registers.
    duty_t  period_reg;
    ticks_t prescale_reg;
    ticks_t interval_reg;
    logic   enable_reg;

    // Input stage and result stage.
    pslp_in_t  in_reg;
    logic      in_valid_reg;
    pslp_out_t out_reg, out_next;
    logic      out_valid_reg;

    logic fire, tick_fire, write_fire, slot_ok, restart;
    logic             led_vec  [LANES];
    duty_t            duty_vec [LANES];
    logic [PTR_W-1:0] wr_addr;
    step_entry_t      wr_entry;

    // Advance the input stage when its request can leave: writes always,
    // ticks when the result register is empty or being drained.
    assign fire       = in_valid_reg &&
                        (in_reg.action == ACT_WRITE || !out_valid_reg || m_ready);
    assign tick_fire  = fire && in_reg.action == ACT_TICK;
    assign write_fire = fire && in_reg.action == ACT_WRITE;
    assign s_ready    = !in_valid_reg || fire;
    assign cfg_ready  = 1'b1;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign slot_ok  = (int'(in_reg.step_index) < MAX_STEPS);
    assign wr_addr  = PTR_W'(in_reg.step_index);
    assign wr_entry = '{target: in_reg.target_duty, ramp: in_reg.ramp_ticks,
                        rest: in_reg.rest_ticks, last: in_reg.last_step};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PWM_PERIOD_RST;
            prescale_reg <= PRESCALE_RST;
            interval_reg <= RESYNC_INTERVAL_RST;
            enable_reg   <= RESYNC_ENABLE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PWM_PERIOD:      period_reg   <= cfg_data[10:0];
                CFG_PRESCALE:        prescale_reg <= cfg_data;
                CFG_RESYNC_INTERVAL: interval_reg <= cfg_data;
                CFG_RESYNC_ENABLE:   enable_reg   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Prescaled resync counter shared by channels one and two.
    pslp_resync u_resync (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick            (tick_fire),
        .prescale_count  (prescale_reg),
        .resync_interval (interval_reg),
        .resync_enable   (enable_reg),
        .restart         (restart)
    );

    // One sequencer per present channel; absent lanes read as zero.
    for (genvar c = 0; c < LANES; c++) begin : g_lane
        if (c < NUM_CHANNELS) begin : g_chan
            pslp_chan_ctrl_t ctrl;
            assign ctrl.tick    = tick_fire;
            assign ctrl.restart = restart && (c == 1 || c == 2);
            assign ctrl.wr_en   = write_fire && slot_ok && (int'(in_reg.channel) == c);

            pslp_channel #(
                .MAX_STEPS (MAX_STEPS)
            ) u_chan (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .pwm_period (period_reg),
                .wr_addr    (wr_addr),
                .wr_entry   (wr_entry),
                .led_on     (led_vec[c]),
                .duty_next  (duty_vec[c])
            );
        end else begin : g_absent
            assign led_vec[c]  = 1'b0;
            assign duty_vec[c] = '0;
        end
    end

    always_comb begin
        out_next.led0_on = led_vec[0];
        out_next.led1_on = led_vec[1];
        out_next.led2_on = led_vec[2];
        out_next.duty0   = duty_vec[0];
        out_next.duty1   = duty_vec[1];
        out_next.duty2   = duty_vec[2];
    end

    // Hold the input request until it leaves; take a new one in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Load a tick's result; drop it once the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (tick_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_fire) begin
            out_reg <= out_next;
        end
    end

endmodule

[rtl/core/pslp_channel.sv]
// One LED channel: pattern memory, PWM counter and fade sequencer.
module pslp_channel #(
    parameter int  MAX_STEPS = 8,
    localparam int PTR_W     = $clog2(MAX_STEPS)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pslp_pkg::pslp_chan_ctrl_t ctrl,
    input  pslp_pkg::duty_t         pwm_period,
    input  logic [PTR_W-1:0]        wr_addr,
    input  pslp_pkg::step_entry_t   wr_entry,
    output logic                    led_on,
    output pslp_pkg::duty_t         duty_next
);
    import pslp_pkg::*;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_STEPS - 1);

    step_entry_t mem [MAX_STEPS];
    step_entry_t rd_reg;
    step_entry_t first_reg;

    mode_t            mode_reg,  mode_next,  mode_cur,  mode_step;
    duty_t            duty_reg,  duty_nx,    duty_cur,  duty_step;
    duty_t            goal_reg,  goal_next,  goal_cur,  goal_step;
    ticks_t           wait_reg,  wait_next,  wait_dec,  wait_step;
    ticks_t           ramp_reg,  ramp_next,  ramp_step;
    ticks_t           rest_reg,  rest_next,  rest_step;
    duty_t            pwm_reg,   pwm_next,   pwm_adv,   pwm_after;
    logic [PTR_W-1:0] ptr_reg,   ptr_next,   ptr_cur,   ptr_step;
    step_entry_t      entry;
    logic             led_now;

    // Delay decrement, PWM and restart, in tick order.
    always_comb begin
        wait_dec = (wait_reg != 16'd0) ? wait_reg - 16'd1 : wait_reg;
        if (pwm_reg < pwm_period) begin
            pwm_adv = pwm_reg + 11'd1;
            led_now = (pwm_adv <= duty_reg);
        end else begin
            pwm_adv = 11'd0;
            led_now = 1'b0;
        end
        pwm_after = ctrl.restart ? 11'd0 : pwm_adv;
        duty_cur  = ctrl.restart ? 11'd0 : duty_reg;
        goal_cur  = ctrl.restart ? 11'd0 : goal_reg;
        mode_cur  = ctrl.restart ? MODE_LOAD : mode_reg;
        ptr_cur   = ctrl.restart ? '0 : ptr_reg;
        entry     = ctrl.restart ? first_reg : rd_reg;
    end

    // Next mode of the sequencer.
    always_comb begin
        mode_step = mode_cur;
        case (mode_cur)
            MODE_LOAD: begin
                if (entry.ramp == 16'd0) begin
                    mode_step = MODE_JUMP;
                end else if (entry.target == duty_cur) begin
                    mode_step = MODE_REST;
                end else if (entry.target > duty_cur) begin
                    mode_step = MODE_UP;
                end else begin
                    mode_step = MODE_DOWN;
                end
            end
            MODE_UP, MODE_DOWN: begin
                if (duty_cur == goal_cur && wait_dec == 16'd0) begin
                    mode_step = MODE_REST;
                end else if (ramp_reg != 16'd0) begin
                    mode_step = (mode_cur == MODE_UP) ? MODE_WAIT_UP : MODE_WAIT_DOWN;
                end
            end
            MODE_WAIT_UP:   if (wait_dec == 16'd0) mode_step = MODE_UP;
            MODE_WAIT_DOWN: if (wait_dec == 16'd0) mode_step = MODE_DOWN;
            MODE_JUMP:      mode_step = MODE_REST;
            MODE_REST:      if (wait_dec == 16'd0) mode_step = MODE_LOAD;
            default:        mode_step = MODE_LOAD;
        endcase
    end

    // Datapath of the sequencer.
    always_comb begin
        duty_step = duty_cur;
        goal_step = goal_cur;
        wait_step = wait_dec;
        ramp_step = ramp_reg;
        rest_step = rest_reg;
        ptr_step  = ptr_cur;
        case (mode_cur)
            MODE_LOAD: begin
                goal_step = entry.target;
                ramp_step = entry.ramp;
                wait_step = entry.ramp;
                rest_step = entry.rest;
                ptr_step  = (entry.last || ptr_cur == LAST_SLOT) ? '0 : ptr_cur + PTR_W'(1);
            end
            MODE_UP, MODE_DOWN: begin
                if (duty_cur == goal_cur && wait_dec == 16'd0) begin
                    wait_step = rest_reg;
                end else begin
                    if (ramp_reg != 16'd0) begin
                        wait_step = ramp_reg;
                    end
                    duty_step = (mode_cur == MODE_UP) ? duty_cur + 11'd1 : duty_cur - 11'd1;
                end
            end
            MODE_JUMP: begin
                wait_step = rest_reg;
                duty_step = goal_cur;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (ctrl.tick) begin
            mode_next = mode_step;
            duty_nx   = duty_step;
            goal_next = goal_step;
            wait_next = wait_step;
            ramp_next = ramp_step;
            rest_next = rest_step;
            pwm_next  = pwm_after;
            ptr_next  = ptr_step;
        end else begin
            mode_next = mode_reg;
            duty_nx   = duty_reg;
            goal_next = goal_reg;
            wait_next = wait_reg;
            ramp_next = ramp_reg;
            rest_next = rest_reg;
            pwm_next  = pwm_reg;
            ptr_next  = ptr_reg;
        end
    end

    assign led_on    = led_now;
    assign duty_next = duty_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_LOAD;
            duty_reg <= '0;
            goal_reg <= '0;
            wait_reg <= '0;
            ramp_reg <= '0;
            rest_reg <= '0;
            pwm_reg  <= '0;
            ptr_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            duty_reg <= duty_nx;
            goal_reg <= goal_next;
            wait_reg <= wait_next;
            ramp_reg <= ramp_next;
            rest_reg <= rest_next;
            pwm_reg  <= pwm_next;
            ptr_reg  <= ptr_next;
        end
    end

    // Prefetch the step the pointer will select; forward a same-slot write.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (ctrl.wr_en && wr_addr == ptr_next) begin
            rd_reg <= wr_entry;
        end else begin
            rd_reg <= mem[ptr_next];
        end
        if (ctrl.wr_en && wr_addr == '0) begin
            first_reg <= wr_entry;
        end
    end

endmodule

[rtl/core/pslp_resync.sv]
// Prescaler and long resync counter that restart channels one and two.
module pslp_resync (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            tick,
    input  pslp_pkg::ticks_t prescale_count,
    input  pslp_pkg::ticks_t resync_interval,
    input  logic            resync_enable,
    output logic            restart
);
    import pslp_pkg::*;

    ticks_t prescale_reg, prescale_next;
    ticks_t resync_reg,   resync_next;
    ticks_t resync_dec;

    always_comb begin
        prescale_next = prescale_reg;
        resync_dec    = resync_reg;
        if (prescale_reg != 16'd0) begin
            prescale_next = prescale_reg - 16'd1;
        end else begin
            prescale_next = prescale_count;
            if (resync_reg != 16'd0) begin
                resync_dec = resync_reg - 16'd1;
            end
        end
        resync_next = (resync_dec == 16'd0) ? resync_interval : resync_dec;
        restart     = tick && resync_enable && (resync_dec == 16'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            resync_reg   <= RESYNC_INTERVAL_RST;
        end else if (tick) begin
            prescale_reg <= prescale_next;
            resync_reg   <= resync_next;
        end
    end

endmodule

[rtl/core/pslp_checker.sv]
// Port-level checker of the LED PWM unit and its bind.
`include "pattern_sequenced_led_pwm_unit_defines.svh"

module pslp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input pslp_pkg::pslp_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input pslp_pkg::pslp_out_t m_data
);
    import pslp_pkg::*;

    // A new result appears only from a tick request that has passed the input register.
    `PSLP_ASSERT_NOW(a_result_from_tick, $rose(m_valid), $past(s_valid && s_ready && s_data.action == ACT_TICK, 2))

    // With the result stage empty the input side never stalls.
    `PSLP_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)

    // A stalled result holds its value.
    `PSLP_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind pattern_sequenced_led_pwm_unit pslp_checker u_pslp_checker (.*);
